FILE: hdl/lsbx_pkg.sv
`timescale 1ns / 1ps

package lsbx_pkg;

  localparam int PIX_W   = 32;
  localparam int BYTE_W  = 8;
  localparam int MAGIC_W = 64;
  localparam int BPS_W   = 4;
  localparam int CHSEL_W = 2;
  localparam int MLEN_W  = 4;
  localparam int REG_IDX_W = 2;

  // Color channels present in one pixel word.
  localparam int CHANNELS = 4;

  // Configuration register indexes.
  localparam logic [REG_IDX_W-1:0] REG_BITS_PER_SAMPLE = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_SELECT  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAGIC_WORD      = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_MAGIC_LENGTH    = 2'd3;

  // Status from the bit packer: a byte finished in this beat.
  typedef struct packed {
    logic              done;
    logic [BYTE_W-1:0] data;
  } pack_out_t;

endpackage

FILE: hdl/lsbx_if.sv
`timescale 1ns / 1ps

interface lsbx_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lsbx_pkg::PIX_W-1:0] pixel;
  logic                       flush;

  modport source (output valid, pixel, flush, input ready);
  modport sink   (input valid, pixel, flush, output ready);
endinterface

interface lsbx_res_if;
  logic                        valid;
  logic                        ready;
  logic                        byte_valid;
  logic [lsbx_pkg::BYTE_W-1:0] out_byte;
  logic                        found;
  logic                        last;

  modport source (output valid, byte_valid, out_byte, found, last, input ready);
  modport sink   (input valid, byte_valid, out_byte, found, last, output ready);
endinterface

FILE: hdl/lsbx_cell.sv
`timescale 1ns / 1ps

module lsbx_cell (
  input  logic                        clk,
  input  logic                        shift,
  input  logic [lsbx_pkg::BYTE_W-1:0] din,
  input  logic [lsbx_pkg::BYTE_W-1:0] magic,
  input  logic                        active,
  output logic [lsbx_pkg::BYTE_W-1:0] q,
  output logic                        hit
);
  import lsbx_pkg::*;

  // Take the neighbor's byte on a push.
  always_ff @(posedge clk) begin
    if (shift) begin
      q <= din;
    end
  end

  // Compare the byte this cell holds after the push.
  assign hit = !active || (din == magic);

endmodule

FILE: hdl/lsbx_packer.sv
`timescale 1ns / 1ps

module lsbx_packer (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        clear,
  input  logic [lsbx_pkg::BYTE_W-1:0] sample,
  input  logic [lsbx_pkg::BPS_W-1:0]  nbits,
  output lsbx_pkg::pack_out_t         pack
);
  import lsbx_pkg::*;

  logic [BYTE_W-1:0]   partial, partial_next;
  logic [2:0]          filled, filled_next;
  logic [4:0]          total;
  logic [4:0]          shamt;
  logic [BYTE_W-1:0]   mask;
  logic [2*BYTE_W-1:0] acc;

  // Line the new bits up right below the bits already filled.
  assign mask  = BYTE_W'((9'h001 << nbits) - 9'h001);
  assign total = 5'(filled) + 5'(nbits);
  assign shamt = 5'(2 * BYTE_W) - total;
  assign acc   = {partial, {BYTE_W{1'b0}}} | ({{BYTE_W{1'b0}}, sample & mask} << shamt);

  assign pack.done = total >= 5'(BYTE_W);
  assign pack.data = acc[2*BYTE_W-1:BYTE_W];

  always_comb begin
    partial_next = partial;
    filled_next  = filled;
    if (clear) begin
      partial_next = '0;
      filled_next  = '0;
    end else if (load) begin
      if (pack.done) begin
        partial_next = acc[BYTE_W-1:0];
        filled_next  = 3'(total - 5'(BYTE_W));
      end else begin
        partial_next = acc[2*BYTE_W-1:BYTE_W];
        filled_next  = total[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      filled  <= '0;
    end else begin
      partial <= partial_next;
      filled  <= filled_next;
    end
  end

endmodule

FILE: hdl/lsb_stego_byte_extractor.sv
`timescale 1ns / 1ps

// Channel | Dir | Beat contents                            | Handshake
// pix     | in  | pixel[31:0], flush                       | valid / ready
// res     | out | byte_valid, out_byte[7:0], found, last   | valid / ready
// cfg     | in  | cfg_index[1:0], cfg_wdata[63:0]          | cfg_wen, no stall
//
// A pixel beat is taken every cycle while no burst runs and res is free;
// a pixel gives at most one byte beat in the cycle after it is taken.
// A terminator match with older held bytes, or a flush, starts a burst that
// sends one held byte per cycle while res takes them, from the window
// cells (up to MAX_MAGIC beats); pix.ready stays low during the burst.
// res is a single output register; it stalls pix only when it is full and
// not taken. Reset is synchronous: window empty, byte packer cleared,
// registers back to bits 1, channel 0, magic 0, length 4.

module lsb_stego_byte_extractor #(
  parameter int MAX_MAGIC = 8
) (
  input  logic                           clk,
  input  logic                           rst,
  lsbx_pix_if.sink                       pix,
  lsbx_res_if.source                     res,
  input  logic                           cfg_wen,
  input  logic [lsbx_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [lsbx_pkg::MAGIC_W-1:0]   cfg_wdata
);
  import lsbx_pkg::*;

  localparam int HW = $clog2(MAX_MAGIC + 1);
  localparam int IW = (MAX_MAGIC > 1) ? $clog2(MAX_MAGIC) : 1;

  // Configuration registers.
  logic [BPS_W-1:0]   bits_per_sample;
  logic [CHSEL_W-1:0] channel_select;
  logic [MAGIC_W-1:0] magic_word;
  logic [MLEN_W-1:0]  magic_length;

  // Control state.
  logic [HW-1:0] held, held_next;
  logic          terminated, term_next;
  logic          drain_active, drain_next;
  logic          drain_flush, dflush_next;

  // Output register.
  logic              ovalid, ov_next;
  logic              obv, obv_next;
  logic [BYTE_W-1:0] obyte, ob_next;
  logic              ofound, of_next;
  logic              olast, ol_next;

  logic [BPS_W-1:0]   nb_eff;
  logic [CHSEL_W-1:0] ch_eff;
  logic [HW-1:0]      len_eff;
  logic [BYTE_W-1:0]  sample;
  pack_out_t          pack;

  logic                 adv;
  logic                 acc_pix, acc_flush;
  logic                 push, pop, match;
  logic [HW-1:0]        held_after, extra, stop;
  logic                 drain_last;
  logic [IW-1:0]        rd_idx;
  logic [BYTE_W-1:0]    oldest;
  logic [BYTE_W-1:0]    win [MAX_MAGIC];
  logic [MAX_MAGIC-1:0] hit;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_sample <= BPS_W'(1);
      channel_select  <= '0;
      magic_word      <= '0;
      magic_length    <= MLEN_W'(4);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_BITS_PER_SAMPLE: bits_per_sample <= cfg_wdata[BPS_W-1:0];
        REG_CHANNEL_SELECT:  channel_select  <= cfg_wdata[CHSEL_W-1:0];
        REG_MAGIC_WORD:      magic_word      <= cfg_wdata;
        REG_MAGIC_LENGTH:    magic_length    <= cfg_wdata[MLEN_W-1:0];
        default:             magic_length    <= magic_length;
      endcase
    end
  end

  // Clamp register values to their working ranges.
  always_comb begin
    priority if (bits_per_sample == '0)
      nb_eff = BPS_W'(1);
    else if (int'(bits_per_sample) > BYTE_W)
      nb_eff = BPS_W'(BYTE_W);
    else
      nb_eff = bits_per_sample;

    if (int'(channel_select) >= CHANNELS)
      ch_eff = CHSEL_W'(CHANNELS - 1);
    else
      ch_eff = channel_select;

    priority if (magic_length == '0)
      len_eff = HW'(1);
    else if (int'(magic_length) > MAX_MAGIC)
      len_eff = HW'(MAX_MAGIC);
    else
      len_eff = HW'(magic_length);
  end

  assign sample = pix.pixel[{ch_eff, 3'b000} +: BYTE_W];

  // Handshake: the output register frees up when empty or being taken.
  assign adv       = !ovalid || res.ready;
  assign pix.ready = adv && !drain_active;
  assign acc_pix   = pix.valid && pix.ready && !pix.flush && !terminated;
  assign acc_flush = pix.valid && pix.ready && pix.flush;

  lsbx_packer u_packer (
    .clk    (clk),
    .rst    (rst),
    .load   (acc_pix),
    .clear  (acc_flush || match),
    .sample (sample),
    .nbits  (nb_eff),
    .pack   (pack)
  );

  // Window chain: cell 0 holds the newest byte, cell held-1 the oldest.
  for (genvar j = 0; j < MAX_MAGIC; j++) begin : g_cell
    logic [BYTE_W-1:0] din;
    if (j == 0) begin : g_head
      assign din = pack.data;
    end else begin : g_link
      assign din = win[j-1];
    end
    lsbx_cell u_cell (
      .clk    (clk),
      .shift  (push),
      .din    (din),
      .magic  (magic_word[BYTE_W*j +: BYTE_W]),
      .active (HW'(j) < len_eff),
      .q      (win[j]),
      .hit    (hit[j])
    );
  end

  assign push       = acc_pix && pack.done;
  assign pop        = push && (held >= len_eff);
  assign held_after = pop ? held : held + HW'(1);
  assign match      = push && (held_after >= len_eff) && (&hit);
  assign extra      = held_after - len_eff;

  assign rd_idx     = IW'(held - HW'(1));
  assign oldest     = win[rd_idx];
  assign stop       = drain_flush ? '0 : len_eff;
  assign drain_last = (held - HW'(1)) == stop;

  always_comb begin
    held_next   = held;
    term_next   = terminated;
    drain_next  = drain_active;
    dflush_next = drain_flush;
    ov_next     = ovalid;
    obv_next    = obv;
    ob_next     = obyte;
    of_next     = ofound;
    ol_next     = olast;
    if (adv) begin
      ov_next = 1'b0;
      if (drain_active) begin
        // Burst: send the oldest held byte, stop at the terminator or empty.
        ov_next   = 1'b1;
        obv_next  = 1'b1;
        ob_next   = oldest;
        ol_next   = drain_last;
        of_next   = drain_last && !drain_flush;
        held_next = drain_last ? '0 : held - HW'(1);
        if (drain_last) begin
          drain_next = 1'b0;
        end
      end else begin
        if (push) begin
          held_next = held_after;
        end
        if (pop) begin
          ov_next  = 1'b1;
          obv_next = 1'b1;
          ob_next  = oldest;
          ol_next  = !(match && (extra != '0));
          of_next  = match && (extra == '0);
        end else if (match && (extra == '0)) begin
          // Match with nothing to release: a bare found beat.
          ov_next  = 1'b1;
          obv_next = 1'b0;
          ob_next  = '0;
          of_next  = 1'b1;
          ol_next  = 1'b1;
        end
        if (match) begin
          term_next = 1'b1;
          if (extra == '0) begin
            held_next = '0;
          end else begin
            drain_next  = 1'b1;
            dflush_next = 1'b0;
          end
        end
        if (acc_flush) begin
          term_next = 1'b0;
          if (held != '0) begin
            drain_next  = 1'b1;
            dflush_next = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held         <= '0;
      terminated   <= 1'b0;
      drain_active <= 1'b0;
      drain_flush  <= 1'b0;
      ovalid       <= 1'b0;
    end else begin
      held         <= held_next;
      terminated   <= term_next;
      drain_active <= drain_next;
      drain_flush  <= dflush_next;
      ovalid       <= ov_next;
    end
  end

  // Hold the payload while the beat waits.
  always_ff @(posedge clk) begin
    obv    <= obv_next;
    obyte  <= ob_next;
    ofound <= of_next;
    olast  <= ol_next;
  end

  assign res.valid      = ovalid;
  assign res.byte_valid = obv;
  assign res.out_byte   = obyte;
  assign res.found      = ofound;
  assign res.last       = olast;

`ifndef ASSERT_OFF
  a_held_range: assert property (@(posedge clk) disable iff (rst)
    held <= HW'(MAX_MAGIC))
    else $error("window count beyond cell count");

  a_drain_above_stop: assert property (@(posedge clk) disable iff (rst)
    drain_active |-> (held > stop))
    else $error("burst running with no byte left to send");

  a_found_is_last: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.found) |-> res.last)
    else $error("found beat not marked last");

  a_empty_beat: assert property (@(posedge clk) disable iff (rst)
    (res.valid && !res.byte_valid) |-> (res.found && (res.out_byte == '0)))
    else $error("beat without byte is not a bare found beat");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    acc_flush |=> !terminated)
    else $error("flush left the block terminated");
`endif

endmodule
